// File: hdl/bpu_pkg.sv
// Shared types and constants of the bitmap pixel unpacker.
package bpu_pkg;

  // Pixel format register codes
  localparam logic [3:0] FMT_1BPP   = 4'd0;
  localparam logic [3:0] FMT_4BPP   = 4'd1;
  localparam logic [3:0] FMT_8BPP   = 4'd2;
  localparam logic [3:0] FMT_444    = 4'd3;
  localparam logic [3:0] FMT_555    = 4'd4;
  localparam logic [3:0] FMT_565    = 4'd5;
  localparam logic [3:0] FMT_666    = 4'd6;
  localparam logic [3:0] FMT_BGR24  = 4'd7;
  localparam logic [3:0] FMT_COPY32 = 4'd8;

  // Item modes
  localparam logic MODE_PAL_WR = 1'b0;
  localparam logic MODE_PIXEL  = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [2:0] LAST_SUB_1BPP = 3'd7;
  localparam logic [2:0] LAST_SUB_4BPP = 3'd1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // What the back end has to do with a queued item
  typedef enum logic [2:0] {
    KIND_PAL_WR,
    KIND_LUT1,
    KIND_LUT4,
    KIND_LUT8,
    KIND_DIRECT
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  last_sub;  // sub-pixel index of the final pixel
    logic [7:0]  idx;       // palette index or source byte
    logic [31:0] argb;      // decoded colour or palette write colour
  } entry_t;

endpackage

// File: hdl/bpu_front.sv
// Front end: holds the format register, accepts and classifies items.
module bpu_front #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 mode_i,
  input  logic [7:0]           palette_index_i,
  input  logic [23:0]          palette_color_i,
  input  logic [31:0]          raw_bits_i,
  input  logic [3:0]           pixel_count_i,
  output logic                 push_o,
  output bpu_pkg::entry_t      entry_o
);

  logic [3:0] fmt_q;
  logic       keep;
  logic       idx_ok;
  logic [7:0] byte_in;

  // Hold the pixel format
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= bpu_pkg::FMT_COPY32;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  assign byte_in = raw_bits_i[7:0];
  assign idx_ok  = {1'b0, palette_index_i} < 9'(PALETTE_DEPTH);

  // Classify the item and decode packed formats
  always_comb begin
    keep           = 1'b1;
    entry_o.kind     = bpu_pkg::KIND_DIRECT;
    entry_o.last_sub = 3'd0;
    entry_o.idx      = byte_in;
    entry_o.argb     = 32'd0;
    if (mode_i == bpu_pkg::MODE_PAL_WR) begin
      entry_o.kind = bpu_pkg::KIND_PAL_WR;
      entry_o.idx  = palette_index_i;
      entry_o.argb = {8'd0, palette_color_i};
      keep         = idx_ok;
    end else begin
      case (fmt_q)
        bpu_pkg::FMT_1BPP: begin
          entry_o.kind = bpu_pkg::KIND_LUT1;
          if (pixel_count_i > 4'd8) begin
            entry_o.last_sub = bpu_pkg::LAST_SUB_1BPP;
          end else if (pixel_count_i == 4'd0) begin
            entry_o.last_sub = 3'd0;
          end else begin
            entry_o.last_sub = 3'(pixel_count_i - 4'd1);
          end
        end
        bpu_pkg::FMT_4BPP: begin
          entry_o.kind     = bpu_pkg::KIND_LUT4;
          entry_o.last_sub = (pixel_count_i >= 4'd2) ? bpu_pkg::LAST_SUB_4BPP : 3'd0;
        end
        bpu_pkg::FMT_8BPP: begin
          entry_o.kind = bpu_pkg::KIND_LUT8;
        end
        bpu_pkg::FMT_444: begin
          entry_o.argb = {bpu_pkg::ALPHA_OPAQUE, raw_bits_i[11:8], 4'd0,
                          raw_bits_i[7:4], 4'd0, raw_bits_i[3:0], 4'd0};
        end
        bpu_pkg::FMT_555: begin
          entry_o.argb = {bpu_pkg::ALPHA_OPAQUE, raw_bits_i[14:10], 3'd0,
                          raw_bits_i[9:5], 3'd0, raw_bits_i[4:0], 3'd0};
        end
        bpu_pkg::FMT_565: begin
          entry_o.argb = {bpu_pkg::ALPHA_OPAQUE, raw_bits_i[15:11], 3'd0,
                          raw_bits_i[10:5], 2'd0, raw_bits_i[4:0], 3'd0};
        end
        bpu_pkg::FMT_666: begin
          entry_o.argb = {bpu_pkg::ALPHA_OPAQUE, raw_bits_i[17:12], 2'd0,
                          raw_bits_i[11:6], 2'd0, raw_bits_i[5:0], 2'd0};
        end
        bpu_pkg::FMT_BGR24: begin
          entry_o.argb = {bpu_pkg::ALPHA_OPAQUE, raw_bits_i[23:0]};
        end
        bpu_pkg::FMT_COPY32: begin
          entry_o.argb = raw_bits_i;
        end
        default: begin
          // unknown format: drop the item
          keep = 1'b0;
        end
      endcase
    end
  end

  assign push_o = in_valid_i && in_ready_i && keep;

endmodule

// File: hdl/bpu_queue.sv
// Short queue of classified items between front and back end.
module bpu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bpu_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bpu_pkg::entry_t head_o
);

  bpu_pkg::entry_t                  slot_q [bpu_pkg::QUEUE_DEPTH];
  logic [bpu_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [bpu_pkg::QCNT_W-1:0]       count_q;

  assign full_o  = count_q == bpu_pkg::QCNT_W'(bpu_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = slot_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/bpu_back.sv
// Back end: palette memory, sub-pixel sequencer and output register.
module bpu_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  bpu_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic [7:0]      alpha_o,
  output logic            last_pixel_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] rd_data_q;
  logic [2:0]  sub_q, sub_d;
  logic        b_valid_q, b_valid_d;
  logic        b_lut_q, b_oor_q, b_last_q;
  logic [31:0] b_argb_q;
  logic        adv, is_wr, is_lut, fire_wr, fire_px, last_sub, lut_ok;
  logic [7:0]  lut_idx;
  logic [23:0] pal_rgb;

  assign adv      = !b_valid_q || out_ready_i;
  assign is_wr    = head_i.kind == bpu_pkg::KIND_PAL_WR;
  assign is_lut   = head_i.kind != bpu_pkg::KIND_DIRECT;
  assign fire_wr  = q_valid_i && is_wr;
  assign fire_px  = q_valid_i && !is_wr && adv;
  assign last_sub = sub_q == head_i.last_sub;
  assign pop_o    = fire_wr || (fire_px && last_sub);
  assign sub_d    = fire_px ? (last_sub ? 3'd0 : sub_q + 3'd1) : sub_q;
  assign b_valid_d = adv ? fire_px : b_valid_q;

  // Pick the palette index of the current sub-pixel
  always_comb begin
    case (head_i.kind)
      bpu_pkg::KIND_LUT1: lut_idx = {7'd0, head_i.idx[3'd7 - sub_q]};
      bpu_pkg::KIND_LUT4: lut_idx = (sub_q == 3'd0) ? {4'd0, head_i.idx[7:4]}
                                                    : {4'd0, head_i.idx[3:0]};
      default:            lut_idx = head_i.idx;
    endcase
  end

  assign lut_ok = {1'b0, lut_idx} < 9'(PALETTE_DEPTH);

  // Palette memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (fire_wr) begin
      pal_mem[head_i.idx[AW-1:0]] <= head_i.argb[23:0];
    end
    if (fire_px && is_lut && lut_ok) begin
      rd_data_q <= pal_mem[lut_idx[AW-1:0]];
    end
  end

  // Load the output stage
  always_ff @(posedge clk_i) begin
    if (fire_px) begin
      b_lut_q  <= is_lut;
      b_oor_q  <= !lut_ok;
      b_last_q <= last_sub;
      b_argb_q <= head_i.argb;
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q     <= 3'd0;
      b_valid_q <= 1'b0;
    end else begin
      sub_q     <= sub_d;
      b_valid_q <= b_valid_d;
    end
  end

  // Drive the result item
  assign pal_rgb      = b_oor_q ? 24'd0 : rd_data_q;
  assign out_valid_o  = b_valid_q;
  assign red_o        = b_lut_q ? pal_rgb[23:16] : b_argb_q[23:16];
  assign green_o      = b_lut_q ? pal_rgb[15:8]  : b_argb_q[15:8];
  assign blue_o       = b_lut_q ? pal_rgb[7:0]   : b_argb_q[7:0];
  assign alpha_o      = b_lut_q ? bpu_pkg::ALPHA_OPAQUE : b_argb_q[31:24];
  assign last_pixel_o = b_last_q;

endmodule

// File: hdl/bitmap_pixel_unpacker.sv
// Top level of the bitmap pixel unpacker.
//
// Input channel (in_valid_i/in_ready_o) takes one item per cycle while the
// queue is not full. Mode 0 writes palette_color_i to palette entry
// palette_index_i and yields no result; mode 1 decodes raw_bits_i per the
// pixel format register. Output channel (out_valid_o/out_ready_i) gives
// one pixel per cycle while out_ready_i is high, with last_pixel_o high on
// the final pixel of each item. The user must write the format register
// with cfg_we_i/cfg_wdata_i only while idle; the block does not enforce
// this. Results are registered in the queue, then the output stage.
// Single-pixel formats take one item per cycle while the output does not
// stall; 1 and 4 bpp items give their pixels one at a time via the single
// palette read port. Palette writes use the back end but no output cycle.
// A four-entry queue parts the front end from the back end, so input is
// still taken while the output stalls, until the queue fills. Reset sets
// the format to 32-bit copy and empties queue and output stage; the
// palette is not cleared and holds undefined data until written.
module bitmap_pixel_unpacker #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  palette_index_i,
  input  logic [23:0] palette_color_i,
  input  logic [31:0] raw_bits_i,
  input  logic [3:0]  pixel_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_pixel_o
);

  logic            push, full, q_valid, pop;
  bpu_pkg::entry_t entry, head;

  assign in_ready_o = !full;

  bpu_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .mode_i          (mode_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .raw_bits_i      (raw_bits_i),
    .pixel_count_i   (pixel_count_i),
    .push_o          (push),
    .entry_o         (entry)
  );

  bpu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  bpu_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

// File: hdl/bpu_checker.sv
// Port checker of the bitmap pixel unpacker and its bind.
module bpu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [7:0]  alpha_o,
  input logic        last_pixel_o
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) &&
      $stable(green_o) && $stable(blue_o) && $stable(alpha_o) &&
      $stable(last_pixel_o))
    else $error("stalled result changed");

  // Follow a taken non-final pixel with the next one at once
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_pixel_o |=> out_valid_o)
    else $error("gap inside a multi-pixel item");

  // Only the 1 and 4 bpp palette formats give several pixels, always opaque
  a_burst_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pixel_o |-> alpha_o == 8'hFF)
    else $error("non-final pixel not opaque");

  // Leave reset with no result pending
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result pending after reset");

endmodule

bind bitmap_pixel_unpacker bpu_checker u_bpu_checker (.*);
